>>> sv/gamepad_serial_port_with_turbo_assert.svh
// Assertion macros for the game-pad serial port
`ifndef GAMEPAD_SERIAL_PORT_WITH_TURBO_ASSERT_SVH
`define GAMEPAD_SERIAL_PORT_WITH_TURBO_ASSERT_SVH

// same-cycle implication
`define GSPT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gspt assertion failed");

// next-cycle implication
`define GSPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gspt assertion failed");

`endif

>>> sv/gspt_pkg.sv
// Types, codes and direction remap shared by the game-pad port modules
package gspt_pkg;

	localparam logic [1:0] MODE_STROBE = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_EVENT  = 2'd2;
	localparam logic [1:0] MODE_TICK   = 2'd3;

	localparam logic [3:0] BTN_A      = 4'd0;
	localparam logic [3:0] BTN_B      = 4'd1;
	localparam logic [3:0] BTN_SELECT = 4'd2;
	localparam logic [3:0] BTN_START  = 4'd3;
	localparam logic [3:0] BTN_UP     = 4'd4;
	localparam logic [3:0] BTN_DOWN   = 4'd5;
	localparam logic [3:0] BTN_LEFT   = 4'd6;
	localparam logic [3:0] BTN_RIGHT  = 4'd7;
	localparam logic [3:0] BTN_TURBO_A = 4'd8;
	localparam logic [3:0] BTN_TURBO_B = 4'd9;

	localparam logic [2:0] K_UP    = 3'd4;
	localparam logic [2:0] K_DOWN  = 3'd5;
	localparam logic [2:0] K_LEFT  = 3'd6;
	localparam logic [2:0] K_RIGHT = 3'd7;
	localparam logic [2:0] HOLD_NONE = 3'd0;

	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] CFG_TURBO_A_PERIOD   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TURBO_B_PERIOD   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ALLOW_OPPOSITE   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROTATION_QUARTER = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_MIRROR_HORIZONTAL = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROTATE_INPUTS    = 3'd5;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;
	localparam int Q_CNT_W = 2;

	typedef enum logic [2:0] {
		OP_STROBE,
		OP_READ,
		OP_BTN,
		OP_DIR,
		OP_TURBO,
		OP_TICK,
		OP_BAD
	} op_t;

	typedef struct packed {
		logic [7:0] turbo_a_period;
		logic [7:0] turbo_b_period;
		logic       allow_opposite;
		logic [1:0] rotation_quarter;
		logic       mirror_horizontal;
		logic       rotate_inputs_enable;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic       write_bit;
		logic [2:0] read_shift;
		logic       pressed;
		logic [2:0] idx;
		logic [2:0] opp;
		logic       axis_h;
		logic       tsel;
	} cmd_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] cnt;
		logic               full;
		logic               empty;
	} q_stat_t;

	typedef logic [3:0][2:0] dir_t;

	// dir[0] up, dir[1] down, dir[2] left, dir[3] right after remap
	function automatic dir_t remap(cfg_t c);
		dir_t       d;
		logic [2:0] t;
		d[0] = K_UP;
		d[1] = K_DOWN;
		d[2] = K_LEFT;
		d[3] = K_RIGHT;
		if (((c.rotation_quarter != 2'd0) || c.mirror_horizontal) && c.rotate_inputs_enable) begin
			case (c.rotation_quarter)
				2'd0: begin
					if (c.mirror_horizontal) begin
						t = d[2]; d[2] = d[3]; d[3] = t;
					end
				end
				2'd1: begin
					t = d[2]; d[2] = d[1]; d[1] = t;
					t = d[3]; d[3] = d[0]; d[0] = t;
					if (!c.mirror_horizontal) begin
						t = d[0]; d[0] = d[1]; d[1] = t;
					end
				end
				2'd2: begin
					t = d[0]; d[0] = d[1]; d[1] = t;
					if (!c.mirror_horizontal) begin
						t = d[2]; d[2] = d[3]; d[3] = t;
					end
				end
				default: begin
					t = d[2]; d[2] = d[0]; d[0] = t;
					t = d[3]; d[3] = d[1]; d[1] = t;
					if (!c.mirror_horizontal) begin
						t = d[0]; d[0] = d[1]; d[1] = t;
					end
				end
			endcase
		end
		return d;
	endfunction

endpackage

>>> sv/gspt_if.sv
// Channel interfaces: request, response and configuration write
interface gspt_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       write_bit;
	logic [2:0] read_shift;
	logic [3:0] button;
	logic       pressed;

	modport source (output valid, mode, write_bit, read_shift, button, pressed, input ready);
	modport sink (input valid, mode, write_bit, read_shift, button, pressed, output ready);
endinterface

interface gspt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       event_status;

	modport source (output valid, read_data, event_status, input ready);
	modport sink (input valid, read_data, event_status, output ready);
endinterface

interface gspt_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] addr;
	logic [7:0] wdata;

	modport source (output valid, addr, wdata, input ready);
	modport sink (input valid, addr, wdata, output ready);
endinterface

>>> sv/gspt_front.sv
// Front end: accept request items, decode and remap them into commands
module gspt_front (
	input  gspt_pkg::cfg_t    cfg,
	gspt_req_if.sink          req,
	input  logic              q_full,
	output logic              push,
	output gspt_pkg::cmd_t    cmd
);
	import gspt_pkg::*;

	dir_t dir;

	assign dir = remap(cfg);
	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

	always_comb begin
		cmd = '0;
		cmd.op = OP_BAD;
		cmd.write_bit = req.write_bit;
		cmd.read_shift = req.read_shift;
		cmd.pressed = req.pressed;
		cmd.idx = req.button[2:0];
		cmd.tsel = req.button[0];
		cmd.axis_h = req.button[1];
		unique case (req.mode)
			MODE_STROBE: cmd.op = OP_STROBE;
			MODE_READ:   cmd.op = OP_READ;
			MODE_TICK:   cmd.op = OP_TICK;
			default: begin
				case (req.button) inside
					BTN_A, BTN_B, BTN_SELECT, BTN_START: cmd.op = OP_BTN;
					BTN_UP, BTN_DOWN, BTN_LEFT, BTN_RIGHT: begin
						cmd.op = OP_DIR;
						cmd.idx = dir[req.button[1:0]];
						cmd.opp = dir[req.button[1:0] ^ 2'd1];
					end
					BTN_TURBO_A, BTN_TURBO_B: cmd.op = OP_TURBO;
					default: cmd.op = OP_BAD;
				endcase
			end
		endcase
	end
endmodule

>>> sv/gspt_queue.sv
// Two-entry command queue between front and back end
module gspt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gspt_pkg::cmd_t      wr_cmd,
	input  logic                pop,
	output gspt_pkg::cmd_t      rd_cmd,
	output gspt_pkg::q_stat_t   stat
);
	import gspt_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q;
	logic [Q_AW-1:0]    rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign rd_cmd = entry_q[rd_ptr_q];
	assign stat.cnt = cnt_q;
	assign stat.full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end
endmodule

>>> sv/gspt_back.sv
// Back end: button, hold, turbo and read state, and the response register
module gspt_back #(
	parameter int READ_LENGTH = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gspt_pkg::cfg_t  cfg,
	input  gspt_pkg::cmd_t  cmd,
	input  logic            q_empty,
	output logic            pop,
	gspt_rsp_if.source      rsp
);
	import gspt_pkg::*;

	localparam int POS_W = $clog2(READ_LENGTH);

	logic [7:0]       raw_q, raw_n;
	logic [7:0]       clean_q, clean_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic             latch_q, latch_n;
	logic [2:0]       vhold_q, vhold_n;
	logic [2:0]       hhold_q, hhold_n;
	logic [1:0]       theld_q, theld_n;
	logic [1:0]       tact_q, tact_n;
	logic [1:0][7:0]  tcnt_q, tcnt_n;
	logic             out_valid_q;
	logic [7:0]       read_data_q, read_data_n;
	logic             status_q, status_n;

	logic [2:0]       axis, axis_n;
	logic [POS_W:0]   pos_inc;
	logic [8:0]       nxt;
	logic [8:0]       per;
	logic             bit_rd;

	assign pop = !q_empty && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.event_status = status_q;

	always_comb begin
		raw_n = raw_q;
		clean_n = clean_q;
		pos_n = pos_q;
		latch_n = latch_q;
		vhold_n = vhold_q;
		hhold_n = hhold_q;
		theld_n = theld_q;
		tact_n = tact_q;
		tcnt_n = tcnt_q;
		read_data_n = '0;
		status_n = 1'b0;
		axis = HOLD_NONE;
		axis_n = HOLD_NONE;
		pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
		nxt = '0;
		per = '0;
		bit_rd = ({1'b0, pos_q} < (POS_W+1)'(8)) ? clean_q[pos_q[2:0]] : 1'b0;
		unique case (cmd.op)
			OP_STROBE: begin
				if (latch_q || cmd.write_bit) begin
					pos_n = '0;
				end
				latch_n = cmd.write_bit;
			end
			OP_READ: begin
				read_data_n = 8'(bit_rd) << cmd.read_shift;
				if (!latch_q) begin
					pos_n = (pos_inc >= (POS_W+1)'(READ_LENGTH)) ? '0 : pos_inc[POS_W-1:0];
				end
			end
			OP_BTN: begin
				if (!((cmd.idx == BTN_A[2:0] && tact_q[0]) || (cmd.idx == BTN_B[2:0] && tact_q[1])))
				begin
					raw_n[cmd.idx] = cmd.pressed;
					clean_n[cmd.idx] = cmd.pressed;
				end
			end
			OP_DIR: begin
				raw_n[cmd.idx] = cmd.pressed;
				clean_n[cmd.idx] = cmd.pressed;
				if (!cfg.allow_opposite) begin
					axis = cmd.axis_h ? hhold_q : vhold_q;
					if (axis == HOLD_NONE) begin
						axis_n = raw_n[cmd.idx] ? cmd.idx : cmd.opp;
					end else if (axis == cmd.idx && !raw_n[cmd.idx]) begin
						axis_n = raw_n[cmd.opp] ? cmd.opp : HOLD_NONE;
						clean_n[cmd.opp] = raw_n[cmd.opp];
					end else begin
						axis_n = axis;
					end
					if (axis_n == cmd.idx) begin
						clean_n[cmd.opp] = 1'b0;
					end else if (axis_n == cmd.opp) begin
						clean_n[cmd.idx] = 1'b0;
					end
					if (cmd.axis_h) begin
						hhold_n = axis_n;
					end else begin
						vhold_n = axis_n;
					end
				end
			end
			OP_TURBO: begin
				theld_n[cmd.tsel] = cmd.pressed;
				if (cmd.pressed) begin
					tact_n[cmd.tsel] = 1'b1;
				end
			end
			OP_TICK: begin
				for (int t = 0; t < 2; t++) begin
					if (theld_q[t] || tact_q[t]) begin
						nxt = {1'b0, tcnt_q[t]} + 9'd1;
						per = {1'b0, (t == 0) ? cfg.turbo_a_period : cfg.turbo_b_period};
						if (nxt == per) begin
							tcnt_n[t] = nxt[7:0];
							raw_n[t] = 1'b1;
							clean_n[t] = 1'b1;
							tact_n[t] = 1'b1;
						end else if (nxt > per) begin
							raw_n[t] = 1'b0;
							clean_n[t] = 1'b0;
							tact_n[t] = 1'b0;
							tcnt_n[t] = '0;
						end else begin
							tcnt_n[t] = nxt[7:0];
						end
					end
				end
			end
			default: status_n = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0;
			clean_q <= '0;
			pos_q <= '0;
			latch_q <= 1'b0;
			vhold_q <= HOLD_NONE;
			hhold_q <= HOLD_NONE;
			theld_q <= '0;
			tact_q <= '0;
			tcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				raw_q <= raw_n;
				clean_q <= clean_n;
				pos_q <= pos_n;
				latch_q <= latch_n;
				vhold_q <= vhold_n;
				hhold_q <= hhold_n;
				theld_q <= theld_n;
				tact_q <= tact_n;
				tcnt_q <= tcnt_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			read_data_q <= read_data_n;
			status_q <= status_n;
		end
	end
endmodule

>>> sv/gamepad_serial_port_with_turbo.sv
// Top level of the game-pad serial port with turbo buttons
// One request item is taken every clock cycle while the queue is not full, and each
// gives one response item. The front end decodes the item and remaps directions, a
// two-entry queue holds the command, and the back end updates the button, hold, turbo
// and read-position state and loads the response register as it pops the command. It
// pops a new command whenever the response register is empty or being taken; when the
// response side stalls, the queue fills and request ready drops once two items wait in it.
// Configuration writes are taken in any cycle and should be made while the port is idle.
`include "gamepad_serial_port_with_turbo_assert.svh"

module gamepad_serial_port_with_turbo #(
	parameter int READ_LENGTH = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	gspt_req_if.sink     req,
	gspt_rsp_if.source   rsp,
	gspt_cfg_if.sink     cfg
);
	import gspt_pkg::*;

	cfg_t    cfg_q;
	cmd_t    front_cmd;
	cmd_t    head_cmd;
	logic    push;
	logic    pop;
	q_stat_t q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turbo_a_period <= 8'd2;
			cfg_q.turbo_b_period <= 8'd2;
			cfg_q.allow_opposite <= 1'b0;
			cfg_q.rotation_quarter <= 2'd0;
			cfg_q.mirror_horizontal <= 1'b0;
			cfg_q.rotate_inputs_enable <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_TURBO_A_PERIOD:    cfg_q.turbo_a_period <= cfg.wdata;
				CFG_TURBO_B_PERIOD:    cfg_q.turbo_b_period <= cfg.wdata;
				CFG_ALLOW_OPPOSITE:    cfg_q.allow_opposite <= cfg.wdata[0];
				CFG_ROTATION_QUARTER:  cfg_q.rotation_quarter <= cfg.wdata[1:0];
				CFG_MIRROR_HORIZONTAL: cfg_q.mirror_horizontal <= cfg.wdata[0];
				CFG_ROTATE_INPUTS:     cfg_q.rotate_inputs_enable <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	gspt_front u_front (
		.cfg    (cfg_q),
		.req    (req),
		.q_full (q_stat.full),
		.push   (push),
		.cmd    (front_cmd)
	);

	gspt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.stat   (q_stat)
	);

	gspt_back #(
		.READ_LENGTH (READ_LENGTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cmd     (head_cmd),
		.q_empty (q_stat.empty),
		.pop     (pop),
		.rsp     (rsp)
	);

	`GSPT_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.cnt <= Q_CNT_W'(Q_DEPTH))
	`GSPT_ASSERT_NEXT(a_accept_queued, req.valid && req.ready, !q_stat.empty)
	`GSPT_ASSERT_NOW(a_read_onehot, rsp.valid, $onehot0(rsp.read_data))
	`GSPT_ASSERT_NOW(a_status_no_data, rsp.valid && rsp.event_status, rsp.read_data == 8'd0)
endmodule

>>> tb/gamepad_serial_port_with_turbo_checker.sv
// Checker for the game-pad port: tracks port state, predicts each response item and compares
module gamepad_serial_port_with_turbo_checker #(
	parameter int READ_LENGTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	gspt_req_if  req,
	gspt_rsp_if  rsp,
	gspt_cfg_if  cfg,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count
);
	import gspt_pkg::*;

	typedef struct packed {
		logic [7:0] read_data;
		logic       event_status;
	} port_rsp_t;

	typedef logic [3:0][2:0] dir_set_t;

	logic [7:0] period_a;
	logic [7:0] period_b;
	logic       allow_opp;
	logic [1:0] rot_q;
	logic       mirror_h;
	logic       remap_en;

	logic       raw_btn [8];
	logic       clean_btn [8];
	logic [4:0] rd_pos;
	logic       strobe_q;
	logic [2:0] v_hold;
	logic [2:0] h_hold;
	logic       turbo_hold_q [2];
	logic       turbo_act [2];
	logic [7:0] turbo_cnt [2];

	port_rsp_t  expected_rsp [$];

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	// d[0] up, d[1] down, d[2] left, d[3] right as seen on the remapped screen
	function automatic dir_set_t dir_order();
		dir_set_t d;
		d = {K_RIGHT, K_LEFT, K_DOWN, K_UP};
		if (remap_en && ((rot_q != 2'd0) || mirror_h)) begin
			case ({rot_q, mirror_h})
				3'b001: d = {K_LEFT, K_RIGHT, K_DOWN, K_UP};
				3'b010: d = {K_UP, K_DOWN, K_RIGHT, K_LEFT};
				3'b011: d = {K_UP, K_DOWN, K_LEFT, K_RIGHT};
				3'b100: d = {K_LEFT, K_RIGHT, K_UP, K_DOWN};
				3'b101: d = {K_RIGHT, K_LEFT, K_UP, K_DOWN};
				3'b110: d = {K_DOWN, K_UP, K_LEFT, K_RIGHT};
				3'b111: d = {K_DOWN, K_UP, K_RIGHT, K_LEFT};
				default: ;
			endcase
		end
		return d;
	endfunction

	task automatic set_btn(input logic [2:0] idx, input logic v);
		raw_btn[idx] = v;
		clean_btn[idx] = v;
	endtask

	// axis follows the logical direction of the event, not the remapped one
	task automatic hold_update(input logic [2:0] logical, input logic [2:0] src,
			input logic [2:0] opp);
		logic [2:0] axis;
		if (!allow_opp) begin
			axis = (logical == K_LEFT || logical == K_RIGHT) ? h_hold : v_hold;
			if (axis == HOLD_NONE) begin
				axis = raw_btn[src] ? src : opp;
			end else if (axis == src && !raw_btn[src]) begin
				axis = raw_btn[opp] ? opp : HOLD_NONE;
				clean_btn[opp] = raw_btn[opp];
			end
			if (axis == src)
				clean_btn[opp] = 1'b0;
			else if (axis == opp)
				clean_btn[src] = 1'b0;
			if (logical == K_LEFT || logical == K_RIGHT)
				h_hold = axis;
			else
				v_hold = axis;
		end
	endtask

	task automatic turbo_frame(input int t, input logic [7:0] period, input logic [2:0] btn);
		logic [8:0] nxt;
		if (turbo_hold_q[t] || turbo_act[t]) begin
			nxt = {1'b0, turbo_cnt[t]} + 9'd1;
			if (nxt == {1'b0, period}) begin
				turbo_cnt[t] = nxt[7:0];
				set_btn(btn, 1'b1);
				turbo_act[t] = 1'b1;
			end else if (nxt > {1'b0, period}) begin
				set_btn(btn, 1'b0);
				turbo_act[t] = 1'b0;
				turbo_cnt[t] = 8'd0;
			end else begin
				turbo_cnt[t] = nxt[7:0];
			end
		end
	endtask

	task automatic predict_port_response(input logic [1:0] m, input logic wb,
			input logic [2:0] sh, input logic [3:0] bt, input logic pr, output port_rsp_t r);
		dir_set_t d;
		logic     bit_v;
		r = '0;
		d = dir_order();
		case (m)
			MODE_STROBE: begin
				if (strobe_q || wb)
					rd_pos = 5'd0;
				strobe_q = wb;
			end
			MODE_READ: begin
				bit_v = (rd_pos < 5'd8) ? clean_btn[rd_pos[2:0]] : 1'b0;
				r.read_data = {7'd0, bit_v} << sh;
				if (!strobe_q)
					rd_pos = (int'(rd_pos) + 1 >= READ_LENGTH) ? 5'd0 : rd_pos + 5'd1;
			end
			MODE_EVENT: begin
				case (bt)
					BTN_A: if (!turbo_act[0]) set_btn(3'(BTN_A), pr);
					BTN_B: if (!turbo_act[1]) set_btn(3'(BTN_B), pr);
					BTN_SELECT, BTN_START: set_btn(bt[2:0], pr);
					BTN_UP: begin
						set_btn(d[0], pr);
						hold_update(K_UP, d[0], d[1]);
					end
					BTN_DOWN: begin
						set_btn(d[1], pr);
						hold_update(K_DOWN, d[1], d[0]);
					end
					BTN_LEFT: begin
						set_btn(d[2], pr);
						hold_update(K_LEFT, d[2], d[3]);
					end
					BTN_RIGHT: begin
						set_btn(d[3], pr);
						hold_update(K_RIGHT, d[3], d[2]);
					end
					BTN_TURBO_A: begin
						turbo_hold_q[0] = pr;
						if (pr)
							turbo_act[0] = 1'b1;
					end
					BTN_TURBO_B: begin
						turbo_hold_q[1] = pr;
						if (pr)
							turbo_act[1] = 1'b1;
					end
					default: r.event_status = 1'b1;
				endcase
			end
			default: begin
				turbo_frame(0, period_a, 3'(BTN_A));
				turbo_frame(1, period_b, 3'(BTN_B));
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : port_monitor
		port_rsp_t want_r;
		port_rsp_t got_r;
		if (!arst_n) begin
			period_a = 8'd2;
			period_b = 8'd2;
			allow_opp = 1'b0;
			rot_q = 2'd0;
			mirror_h = 1'b0;
			remap_en = 1'b0;
			for (int i = 0; i < 8; i++) begin
				raw_btn[i] = 1'b0;
				clean_btn[i] = 1'b0;
			end
			rd_pos = 5'd0;
			strobe_q = 1'b0;
			v_hold = HOLD_NONE;
			h_hold = HOLD_NONE;
			for (int i = 0; i < 2; i++) begin
				turbo_hold_q[i] = 1'b0;
				turbo_act[i] = 1'b0;
				turbo_cnt[i] = 8'd0;
			end
			expected_rsp.delete();
			fail_count = 0;
			checked_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					CFG_TURBO_A_PERIOD:    period_a = cfg.wdata;
					CFG_TURBO_B_PERIOD:    period_b = cfg.wdata;
					CFG_ALLOW_OPPOSITE:    allow_opp = cfg.wdata[0];
					CFG_ROTATION_QUARTER:  rot_q = cfg.wdata[1:0];
					CFG_MIRROR_HORIZONTAL: mirror_h = cfg.wdata[0];
					CFG_ROTATE_INPUTS:     remap_en = cfg.wdata[0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				predict_port_response(req.mode, req.write_bit, req.read_shift, req.button,
					req.pressed, want_r);
				expected_rsp.push_back(want_r);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("response item with no request outstanding");
				end else begin
					want_r = expected_rsp.pop_front();
					got_r.read_data = rsp.read_data;
					got_r.event_status = rsp.event_status;
					checked_count++;
					if (got_r.read_data !== want_r.read_data)
						report_mismatch($sformatf("read_data got %0h want %0h",
							got_r.read_data, want_r.read_data));
					if (got_r.event_status !== want_r.event_status)
						report_mismatch($sformatf("event_status got %0b want %0b",
							got_r.event_status, want_r.event_status));
				end
			end
		end
		pending_count = expected_rsp.size();
	end

endmodule

>>> tb/gamepad_serial_port_with_turbo_tb.sv
// Testbench top for the game-pad port: clock, reset, stimulus, stalls, watchdog and verdict
module gamepad_serial_port_with_turbo_tb;
	import gspt_pkg::*;

	localparam int READ_LEN    = 24;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;

	gspt_req_if req();
	gspt_rsp_if rsp();
	gspt_cfg_if cfg();

	int send_idle;
	int recv_stall;
	int items_sent;
	int settings_used;
	int quiet_cycles = 0;
	int fail_count;
	int pending_count;
	int checked_count;

	gamepad_serial_port_with_turbo #(
		.READ_LENGTH(READ_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	gamepad_serial_port_with_turbo_checker #(
		.READ_LENGTH(READ_LEN)
	) u_port_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("gamepad_serial_port_with_turbo_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] m, input logic wb, input logic [2:0] sh,
			input logic [3:0] bt, input logic pr);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.write_bit <= wb;
		req.read_shift <= sh;
		req.button <= bt;
		req.pressed <= pr;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_read(input logic [2:0] sh);
		send_item(MODE_READ, 1'($urandom_range(1)), sh, 4'($urandom_range(15)),
			1'($urandom_range(1)));
	endtask

	task automatic send_event(input logic [3:0] bt, input logic pr);
		send_item(MODE_EVENT, 1'($urandom_range(1)), 3'($urandom_range(7)), bt, pr);
	endtask

	task automatic send_strobe(input logic wb);
		send_item(MODE_STROBE, wb, 3'($urandom_range(7)), 4'($urandom_range(15)),
			1'($urandom_range(1)));
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, 1'($urandom_range(1)), 3'($urandom_range(7)),
			4'($urandom_range(15)), 1'($urandom_range(1)));
	endtask

	task automatic write_reg(input logic [2:0] a, input logic [7:0] d);
		cfg.valid <= 1'b1;
		cfg.addr <= a;
		cfg.wdata <= d;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	// drain the port, then write every register
	task automatic apply_settings(input logic [7:0] pa, input logic [7:0] pb,
			input logic ao, input logic [1:0] rq, input logic mh, input logic ri);
		req.valid <= 1'b0;
		wait (pending_count == 0);
		@(negedge clk);
		write_reg(CFG_TURBO_A_PERIOD, pa);
		write_reg(CFG_TURBO_B_PERIOD, pb);
		write_reg(CFG_ALLOW_OPPOSITE, {7'd0, ao});
		write_reg(CFG_ROTATION_QUARTER, {6'd0, rq});
		write_reg(CFG_MIRROR_HORIZONTAL, {7'd0, mh});
		write_reg(CFG_ROTATE_INPUTS, {7'd0, ri});
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic directed_items();
		send_read(3'd0);
		send_event(BTN_A, 1'b1);
		send_event(BTN_SELECT, 1'b1);
		send_event(BTN_UP, 1'b1);
		send_event(BTN_DOWN, 1'b1);
		send_event(BTN_RIGHT, 1'b1);
		send_event(BTN_LEFT, 1'b1);
		send_event(4'd15, 1'b1);
		send_event(4'd10, 1'b0);
		send_strobe(1'b1);
		send_strobe(1'b0);
		for (int i = 0; i < 9; i++)
			send_read(3'(7 - i));
		send_event(BTN_TURBO_A, 1'b1);
		send_tick();
		send_event(BTN_A, 1'b0);
		send_tick();
		send_tick();
		send_event(BTN_TURBO_A, 1'b0);
		send_event(BTN_START, 1'b1);
	endtask

	// latch, release, then shift out a run of bits; sometimes leave the latch set
	task automatic poll_port();
		int n;
		n = $urandom_range(8, 26);
		send_strobe(1'b1);
		if ($urandom_range(9) != 0)
			send_strobe(1'b0);
		repeat (n)
			send_read(3'($urandom_range(7)));
	endtask

	task automatic event_burst();
		int n;
		int r;
		n = $urandom_range(1, 6);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 45)
				send_event(4'($urandom_range(4, 7)), 1'($urandom_range(1)));
			else if (r < 62)
				send_event(4'($urandom_range(0, 3)), 1'($urandom_range(1)));
			else if (r < 75)
				send_event(4'($urandom_range(8, 9)), 1'($urandom_range(1)));
			else if (r < 82)
				send_event(4'($urandom_range(10, 15)), 1'($urandom_range(1)));
			else
				send_tick();
		end
		repeat ($urandom_range(0, 4))
			send_tick();
	endtask

	task automatic run_segment(input int count);
		int start;
		int r;
		start = items_sent;
		while (items_sent - start < count) begin
			r = $urandom_range(99);
			if (r < 40)
				poll_port();
			else if (r < 90)
				event_burst();
			else
				send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
					3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.mode = MODE_STROBE;
		req.write_bit = 1'b0;
		req.read_shift = 3'd0;
		req.button = BTN_A;
		req.pressed = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = CFG_TURBO_A_PERIOD;
		cfg.wdata = 8'd0;
		send_idle = 31;
		recv_stall = 88;
		items_sent = 0;
		settings_used = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_items();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 31 : (ph == 1) ? 88 : 0;
			recv_stall = (ph == 0) ? 88 : (ph == 1) ? 31 : 0;
			for (int sg = 0; sg < 3; sg++) begin
				case (ph * 3 + sg)
					0: apply_settings(8'd1, 8'd255, 1'b0, 2'd0, 1'b0, 1'b0);
					1: apply_settings(8'd255, 8'd1, 1'b1, 2'd3, 1'b1, 1'b1);
					2: apply_settings(8'd0, 8'd3, 1'b0, 2'd1, 1'b0, 1'b1);
					3: apply_settings(8'd2, 8'd4, 1'b0, 2'd2, 1'b0, 1'b1);
					4: apply_settings(8'd3, 8'd1, 1'b0, 2'd0, 1'b1, 1'b1);
					5: apply_settings(8'd1, 8'd2, 1'b1, 2'd1, 1'b1, 1'b1);
					6: apply_settings(8'd4, 8'd2, 1'b0, 2'd3, 1'b0, 1'b1);
					7: apply_settings(8'd2, 8'd2, 1'b0, 2'd2, 1'b1, 1'b1);
					default: apply_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
						1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
				endcase
				run_segment(120);
			end
		end
		req.valid <= 1'b0;
		wait (pending_count == 0);
		repeat (8) @(posedge clk);
		$display("covered %0d request items and %0d response checks over %0d register settings",
			items_sent, checked_count, settings_used + 1);
		$display("stall mix: sender/receiver 31/88 percent, then 88/31, then free running");
		if (fail_count == 0)
			$display("gamepad_serial_port_with_turbo_tb OK");
		else
			$display("gamepad_serial_port_with_turbo_tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/gspt_pkg.sv
sv/gspt_if.sv
sv/gspt_front.sv
sv/gspt_queue.sv
sv/gspt_back.sv
sv/gamepad_serial_port_with_turbo.sv
tb/gamepad_serial_port_with_turbo_checker.sv
tb/gamepad_serial_port_with_turbo_tb.sv
